@@ rtl/mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and codes for the multi-contact debouncer.
// ----------------------------------------------------------------------------
package mcd_pkg;

    // request kinds carried on s_tuser
    localparam logic ACTION_INIT = 1'b0;
    localparam logic ACTION_POLL = 1'b1;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVICE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIN_MAP    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_LVL = 2'd3;

    // register reset values
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [3:0]  SERVICE_RESET  = 4'd0;
    localparam logic [15:0] PIN_MAP_RESET  = 16'h00A9;
    localparam logic        ACTIVE_RESET   = 1'b0;

    localparam int PIN_IDX_W = 4;
    localparam int PINS_W    = 16;
    localparam int STAMP_W   = 32;

    // what one lane reports for the request being taken
    typedef struct packed {
        logic stable;   // stable level after this request
        logic changed;  // stable level flipped on this request
    } lane_stat_t;

endpackage

@@ rtl/multi_contact_debouncer.sv @@
// ----------------------------------------------------------------------------
// multi_contact_debouncer
// Time-based debouncer for one service switch and CONTACTS door contacts.
// ----------------------------------------------------------------------------
// The result of an accepted request is registered and shows on m_tvalid in the cycle after the accept.
// Throughput: one request per cycle while s_tready is high; every lane updates in the accept cycle.
// s_tready drops only while a result is held and m_tready is low.
// Reset clears levels, output valid and the initialised flag; the first
// request after reset loads every channel from its snapshot.
module multi_contact_debouncer #(
    parameter int CONTACTS  = 2,
    parameter int TIME_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,  // sample_time, pin_levels
    input  logic                                s_tuser,  // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // service_changed, service_mode, contact_events, contact_levels, zero pad
    output logic [((2*CONTACTS+2+7)/8)*8-1:0]   m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mcd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mcd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mcd_pkg::*;

    localparam int OUT_W = ((2*CONTACTS+2+7)/8)*8;

    logic [15:0]            interval_reg;
    logic [PIN_IDX_W-1:0]   service_pin_reg;
    logic [15:0]            pin_map_reg;
    logic                   active_reg;
    logic                   ready_reg;

    logic                   accept;
    logic                   init;
    logic [TIME_BITS-1:0]   now;
    logic [PINS_W-1:0]      pins;
    lane_stat_t [CONTACTS:0] lane_stat;
    logic [PIN_IDX_W-1:0]   lane_pin [CONTACTS+1];

    assign s_tready = ~m_tvalid | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign init     = (s_tuser == ACTION_INIT) | ~ready_reg;
    assign now      = s_tdata[TIME_BITS-1:0];
    assign pins     = s_tdata[STAMP_W +: PINS_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg    <= DEBOUNCE_RESET;
            service_pin_reg <= SERVICE_RESET;
            pin_map_reg     <= PIN_MAP_RESET;
            active_reg      <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE:   interval_reg    <= cfg_wdata;
                CFG_SERVICE:    service_pin_reg <= cfg_wdata[PIN_IDX_W-1:0];
                CFG_PIN_MAP:    pin_map_reg     <= cfg_wdata;
                CFG_ACTIVE_LVL: active_reg      <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else if (accept) begin
            ready_reg <= 1'b1;
        end
    end

    assign lane_pin[0] = service_pin_reg;

    genvar g;
    generate
        for (g = 0; g < CONTACTS; g++) begin : g_pin
            assign lane_pin[g+1] = pin_map_reg[PIN_IDX_W*g +: PIN_IDX_W];
        end
        for (g = 0; g <= CONTACTS; g++) begin : g_lane
            mcd_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .en           (accept),
                .init         (init),
                .pin_sel      (lane_pin[g]),
                .pin_levels   (pins),
                .active_level (active_reg),
                .now          (now),
                .interval     (interval_reg),
                .stat         (lane_stat[g])
            );
        end
    endgenerate

    mcd_merge #(
        .CONTACTS (CONTACTS),
        .OUT_W    (OUT_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .lane_stat (lane_stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    a_init_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && init) |=> (m_tdata[0] == 1'b0 && m_tdata[2 +: CONTACTS] == '0))
        else $error("initialisation reported a change");

    a_service_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[2 +: CONTACTS] == '0))
        else $error("contact event reported in service mode");

    a_ready_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(ready_reg))
        else $error("initialised flag lost without reset");

    a_init_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !ready_reg) |-> init)
        else $error("first request after reset not taken as initialisation");

endmodule

@@ rtl/mcd_lane.sv @@
// ----------------------------------------------------------------------------
// mcd_lane
// One debounce channel: pin select, candidate tracking and hold-time check.
// ----------------------------------------------------------------------------
module mcd_lane #(
    parameter int TIME_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              init,
    input  logic [mcd_pkg::PIN_IDX_W-1:0]     pin_sel,
    input  logic [mcd_pkg::PINS_W-1:0]        pin_levels,
    input  logic                              active_level,
    input  logic [TIME_BITS-1:0]              now,
    input  logic [15:0]                       interval,
    output mcd_pkg::lane_stat_t               stat
);
    import mcd_pkg::*;

    logic                 stable_reg, stable_next;
    logic                 cand_reg, cand_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 act;
    logic [TIME_BITS-1:0] elapsed;
    logic                 changed;

    assign act = (pin_levels[pin_sel] == active_level);

    always_comb begin
        cand_next   = act;
        time_next   = (act != cand_reg) ? now : time_reg;
        elapsed     = now - time_next;
        stable_next = stable_reg;
        changed     = 1'b0;
        if (init) begin
            stable_next = act;
            time_next   = now;
        end else if (act != stable_reg && elapsed >= TIME_BITS'(interval)) begin
            stable_next = act;
            changed     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
        end else if (en) begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            time_reg <= time_next;
        end
    end

    assign stat.stable  = stable_next;
    assign stat.changed = changed;

endmodule

@@ rtl/mcd_merge.sv @@
// ----------------------------------------------------------------------------
// mcd_merge
// Combines lane reports into one result and holds it in the output register.
// ----------------------------------------------------------------------------
module mcd_merge #(
    parameter int CONTACTS = 2,
    parameter int OUT_W    = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  mcd_pkg::lane_stat_t [CONTACTS:0]     lane_stat,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [OUT_W-1:0]                     m_tdata
);
    import mcd_pkg::*;

    logic                valid_reg, valid_next;
    logic [OUT_W-1:0]    data_reg, data_next;
    logic [CONTACTS-1:0] events;
    logic [CONTACTS-1:0] levels;
    logic                svc_mode;

    assign svc_mode = lane_stat[0].stable;

    always_comb begin
        for (int i = 0; i < CONTACTS; i++) begin
            levels[i] = lane_stat[i+1].stable;
            // contact events masked while the updated service mode is on
            events[i] = lane_stat[i+1].changed & ~svc_mode;
        end
    end

    always_comb begin
        data_next  = OUT_W'({levels, events, svc_mode, lane_stat[0].changed});
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
